### sv/ppt_pkg.sv
package ppt_pkg;

   typedef enum logic [1:0] {
      OP_PACKET       = 2'd0,
      OP_PLAYED       = 2'd1,
      OP_STREAM_RESET = 2'd2,
      OP_QUERY        = 2'd3
   } op_type;

   // configuration register indexes
   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_TARGET_DEPTH  = 1'b1;

   localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd1000000;
   localparam logic [31:0] TARGET_DEPTH_RESET  = 32'd0;

   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 96;

endpackage

### sv/playout_phase_tracker.sv
// Playout phase tracker. Each transaction on the req_ side is one event (packet, played,
// stream reset or query, selected by req_tuser) and gives exactly one transaction on the
// rsp_ side with the break flag, the break total, the read position and the signed phase
// error. The block is a three-register pipeline: an input register, the tracker state
// (updated in the cycle an event leaves the input register), and the result register.
// One event is taken every clock cycle while no result waits. A waiting result stalls
// the pipeline but empty stages are filled first, so up to two more events are taken
// while a result waits before req_tready drops. Configuration is to be written through
// csr_ only while no event is in flight; the block itself does not enforce this.
module playout_phase_tracker
   import ppt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rtp_stamp[31:0], frame_count[47:32], arrival_time[79:48], time_us[143:80],
   // held_frames[159:144], local_clock[191:160]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [1:0]            req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // break_count[31:0], play_position[63:32], phase_error[95:64]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // timeline_break[0], position_valid[1], error_valid[2]
   output logic [2:0]            rsp_tuser,

   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata
);

   // configuration
   logic [31:0] window_length_ff;
   logic [31:0] target_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
         target_depth_ff  <= TARGET_DEPTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata;
            CSR_TARGET_DEPTH:  target_depth_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake / pipeline moves
   logic in_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic ready3;
   logic ready2;
   logic move12;
   logic move23;

   assign ready3     = !rsp_valid_ff || rsp_tready;
   assign move23     = s2_valid_ff && ready3;
   assign ready2     = !s2_valid_ff || ready3;
   assign move12     = in_valid_ff && ready2;
   assign req_tready = !in_valid_ff || ready2;
   assign rsp_tvalid = rsp_valid_ff;

   // input register
   op_type      op_ff;
   logic [31:0] stamp_ff;
   logic [15:0] frames_ff;
   logic [31:0] arrival_ff;
   logic [63:0] now_ff;
   logic [15:0] held_ff;
   logic [31:0] clk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff      <= op_type'(req_tuser);
         stamp_ff   <= req_tdata[31:0];
         frames_ff  <= req_tdata[47:32];
         arrival_ff <= req_tdata[79:48];
         now_ff     <= req_tdata[143:80];
         held_ff    <= req_tdata[159:144];
         clk_ff     <= req_tdata[191:160];
      end
   end

   // tracker state
   logic [31:0] next_stamp_ff,   next_stamp_in;
   logic        ns_known_ff,     ns_known_in;
   logic [31:0] break_total_ff,  break_total_in;
   logic [15:0] settling_ff,     settling_in;
   logic [31:0] origin_ff,       origin_in;
   logic        origin_known_ff, origin_known_in;
   logic [31:0] cur_min_ff,      cur_min_in;
   logic        cur_known_ff,    cur_known_in;
   logic [31:0] prev_min_ff,     prev_min_in;
   logic        prev_known_ff,   prev_known_in;
   logic [63:0] win_start_ff,    win_start_in;

   logic        is_pkt;
   logic        brk;
   logic [31:0] delay;
   logic [31:0] rel;
   logic [63:0] elapsed;
   logic        roll;
   logic        cur_known_eff;

   always_comb begin
      next_stamp_in   = next_stamp_ff;
      ns_known_in     = ns_known_ff;
      break_total_in  = break_total_ff;
      settling_in     = settling_ff;
      origin_in       = origin_ff;
      origin_known_in = origin_known_ff;
      cur_min_in      = cur_min_ff;
      cur_known_in    = cur_known_ff;
      prev_min_in     = prev_min_ff;
      prev_known_in   = prev_known_ff;
      win_start_in    = win_start_ff;

      is_pkt        = (op_ff == OP_PACKET) && (frames_ff != 16'd0);
      brk           = is_pkt && ns_known_ff && (stamp_ff != next_stamp_ff);
      delay         = arrival_ff - stamp_ff;
      rel           = delay - origin_ff;
      elapsed       = now_ff - win_start_ff;
      roll          = elapsed >= {32'd0, window_length_ff};
      cur_known_eff = cur_known_ff && !roll;

      unique case (op_ff)
         OP_PACKET: begin
            if (is_pkt) begin
               if (brk) begin
                  break_total_in = break_total_ff + 32'd1;
                  settling_in    = held_ff;
               end
               next_stamp_in = stamp_ff + {16'd0, frames_ff};
               ns_known_in   = 1'b1;
               if (brk || !origin_known_ff) begin
                  // timeline (re)start: both windows restart from this delay
                  origin_in       = delay;
                  origin_known_in = 1'b1;
                  cur_min_in      = 32'd0;
                  cur_known_in    = 1'b1;
                  prev_min_in     = 32'd0;
                  prev_known_in   = 1'b0;
                  win_start_in    = now_ff;
               end else begin
                  if (roll) begin
                     prev_min_in   = cur_min_ff;
                     prev_known_in = cur_known_ff;
                     win_start_in  = now_ff;
                  end
                  if (!cur_known_eff || ($signed(rel) < $signed(cur_min_ff))) begin
                     cur_min_in   = rel;
                     cur_known_in = 1'b1;
                  end else begin
                     cur_known_in = cur_known_eff;
                  end
               end
            end
         end
         OP_PLAYED: begin
            settling_in = (settling_ff > frames_ff) ? settling_ff - frames_ff : 16'd0;
         end
         OP_STREAM_RESET: begin
            next_stamp_in   = 32'd0;
            ns_known_in     = 1'b0;
            settling_in     = 16'd0;
            origin_in       = 32'd0;
            origin_known_in = 1'b0;
            cur_min_in      = 32'd0;
            cur_known_in    = 1'b0;
            prev_min_in     = 32'd0;
            prev_known_in   = 1'b0;
            win_start_in    = 64'd0;
         end
         OP_QUERY: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_stamp_ff   <= '0;
         ns_known_ff     <= 1'b0;
         break_total_ff  <= '0;
         settling_ff     <= '0;
         origin_ff       <= '0;
         origin_known_ff <= 1'b0;
         cur_min_ff      <= '0;
         cur_known_ff    <= 1'b0;
         prev_min_ff     <= '0;
         prev_known_ff   <= 1'b0;
         win_start_ff    <= '0;
      end else if (move12) begin
         next_stamp_ff   <= next_stamp_in;
         ns_known_ff     <= ns_known_in;
         break_total_ff  <= break_total_in;
         settling_ff     <= settling_in;
         origin_ff       <= origin_in;
         origin_known_ff <= origin_known_in;
         cur_min_ff      <= cur_min_in;
         cur_known_ff    <= cur_known_in;
         prev_min_ff     <= prev_min_in;
         prev_known_ff   <= prev_known_in;
         win_start_ff    <= win_start_in;
      end
   end

   // per-event values carried beside the state; the state holds this event's
   // result until the event moves on, since the next update shares that edge
   logic        s2_break_ff;
   logic [15:0] s2_held_ff;
   logic [31:0] s2_clk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move12) begin
         s2_break_ff <= brk;
         s2_held_ff  <= held_ff;
         s2_clk_ff   <= clk_ff;
      end
   end

   // result
   logic        pos_ok;
   logic [31:0] position;
   logic        use_prev;
   logic [31:0] least_rel;
   logic        least_ok;
   logic [31:0] least;
   logic        err_ok;
   logic [31:0] err;

   always_comb begin
      pos_ok    = ns_known_ff && (settling_ff == 16'd0);
      position  = next_stamp_ff - {16'd0, s2_held_ff};
      use_prev  = prev_known_ff &&
                  (!cur_known_ff || ($signed(prev_min_ff) < $signed(cur_min_ff)));
      least_rel = use_prev ? prev_min_ff : cur_min_ff;
      least_ok  = origin_known_ff && (cur_known_ff || prev_known_ff);
      least     = origin_ff + least_rel;
      err_ok    = pos_ok && least_ok;
      err       = s2_clk_ff - position - least - target_depth_ff;
   end

   logic        rsp_break_ff;
   logic [31:0] rsp_count_ff;
   logic        rsp_pos_ok_ff;
   logic [31:0] rsp_position_ff;
   logic        rsp_err_ok_ff;
   logic [31:0] rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move23) begin
         rsp_break_ff    <= s2_break_ff;
         rsp_count_ff    <= break_total_ff;
         rsp_pos_ok_ff   <= pos_ok;
         rsp_position_ff <= pos_ok ? position : 32'd0;
         rsp_err_ok_ff   <= err_ok;
         rsp_err_ff      <= err_ok ? err : 32'd0;
      end
   end

   assign rsp_tdata = {rsp_err_ff, rsp_position_ff, rsp_count_ff};
   assign rsp_tuser = {rsp_err_ok_ff, rsp_pos_ok_ff, rsp_break_ff};

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ppt_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic        timeline_break;
      logic [31:0] break_count;
      logic        position_valid;
      logic [31:0] play_position;
      logic        error_valid;
      logic [31:0] phase_error;
   } phase_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic                  csr_index = 1'b0;
   logic [31:0]           csr_wdata = '0;

   // tracker copy kept in step with the block
   logic [31:0] cfg_window_us = WINDOW_LENGTH_RESET;
   logic [31:0] cfg_target = TARGET_DEPTH_RESET;
   logic [31:0] trk_next_stamp = '0;
   logic        trk_next_known = 1'b0;
   logic [31:0] trk_breaks = '0;
   logic [15:0] trk_settle = '0;
   logic [31:0] trk_origin = '0;
   logic        trk_origin_known = 1'b0;
   logic [31:0] trk_cur_min = '0;
   logic        trk_cur_known = 1'b0;
   logic [31:0] trk_prev_min = '0;
   logic        trk_prev_known = 1'b0;
   logic [63:0] trk_window_start = '0;

   phase_report_type expected_reports[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int rsp_hold_cycles = 0;
   int quiet_cycles = 0;

   // synthetic stream used for well-formed traffic
   logic [31:0] gen_stamp;
   logic [63:0] gen_us;
   logic [31:0] gen_delay;
   logic [31:0] gen_clock;

   playout_phase_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic phase_report_type track_event(input op_type op, input logic [31:0] stamp,
         input logic [15:0] frames, input logic [31:0] arrival, input logic [63:0] t_us,
         input logic [15:0] held, input logic [31:0] clk_now);
      phase_report_type r;
      logic [31:0] dly;
      logic [31:0] rel;
      logic [31:0] least;
      logic        have;
      r = '0;
      case (op)
         OP_PACKET: begin
            if (frames != 0) begin
               if (trk_next_known && stamp != trk_next_stamp) begin
                  r.timeline_break = 1'b1;
                  trk_breaks = trk_breaks + 32'd1;
                  trk_settle = held;
               end
               trk_next_stamp = stamp + {16'd0, frames};
               trk_next_known = 1'b1;
               dly = arrival - stamp;
               if (r.timeline_break || !trk_origin_known) begin
                  // both windows restart from this delay
                  trk_origin = dly;
                  trk_origin_known = 1'b1;
                  trk_cur_min = '0;
                  trk_cur_known = 1'b1;
                  trk_prev_min = '0;
                  trk_prev_known = 1'b0;
                  trk_window_start = t_us;
               end else begin
                  if (t_us - trk_window_start >= {32'd0, cfg_window_us}) begin
                     trk_prev_min = trk_cur_min;
                     trk_prev_known = trk_cur_known;
                     trk_cur_known = 1'b0;
                     trk_window_start = t_us;
                  end
                  rel = dly - trk_origin;
                  if (!trk_cur_known || $signed(rel) < $signed(trk_cur_min)) begin
                     trk_cur_min = rel;
                     trk_cur_known = 1'b1;
                  end
               end
            end
         end
         OP_PLAYED: begin
            trk_settle = (trk_settle > frames) ? trk_settle - frames : 16'd0;
         end
         OP_STREAM_RESET: begin
            trk_next_stamp = '0;
            trk_next_known = 1'b0;
            trk_settle = '0;
            trk_origin = '0;
            trk_origin_known = 1'b0;
            trk_cur_min = '0;
            trk_cur_known = 1'b0;
            trk_prev_min = '0;
            trk_prev_known = 1'b0;
            trk_window_start = '0;
         end
         default: begin
         end
      endcase
      r.break_count = trk_breaks;
      r.position_valid = trk_next_known && trk_settle == 0;
      if (r.position_valid) begin
         r.play_position = trk_next_stamp - {16'd0, held};
         have = 1'b0;
         least = '0;
         if (trk_origin_known) begin
            if (trk_cur_known) begin
               least = trk_cur_min;
               have = 1'b1;
            end
            if (trk_prev_known && (!have || $signed(trk_prev_min) < $signed(least))) begin
               least = trk_prev_min;
               have = 1'b1;
            end
            if (have) begin
               r.error_valid = 1'b1;
               r.phase_error = clk_now - r.play_position - (trk_origin + least) - cfg_target;
            end
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
         input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   // predict on every accepted event, compare on every accepted result
   always @(posedge clock) begin
      phase_report_type want;
      if (!reset && req_tvalid && req_tready)
         expected_reports.push_back(track_event(op_type'(req_tuser), req_tdata[31:0],
            req_tdata[47:32], req_tdata[79:48], req_tdata[143:80], req_tdata[159:144],
            req_tdata[191:160]));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $error("result transaction with no event outstanding");
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            check_field("timeline_break", 32'(want.timeline_break), 32'(rsp_tuser[0]));
            check_field("break_count", want.break_count, rsp_tdata[31:0]);
            check_field("position_valid", 32'(want.position_valid), 32'(rsp_tuser[1]));
            check_field("play_position", want.play_position, rsp_tdata[63:32]);
            check_field("error_valid", 32'(want.error_valid), 32'(rsp_tuser[2]));
            check_field("phase_error", want.phase_error, rsp_tdata[95:64]);
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else if (++quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_event(input op_type op, input logic [31:0] stamp,
         input logic [15:0] frames, input logic [31:0] arrival, input logic [63:0] t_us,
         input logic [15:0] held, input logic [31:0] clk_now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {clk_now, held, t_us, arrival, frames, stamp};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] window_us, input logic [31:0] target);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_WINDOW_LENGTH;
      csr_wdata <= window_us;
      @(negedge clock);
      csr_index <= CSR_TARGET_DEPTH;
      csr_wdata <= target;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_window_us = window_us;
      cfg_target = target;
   endtask

   task automatic send_stream_item();
      int unsigned pick;
      logic [31:0] stamp;
      logic [15:0] frames;
      logic [15:0] held;
      pick = $urandom_range(99);
      held = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
      if (pick < 60) begin
         frames = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(480, 1));
         if ($urandom_range(49) == 0)
            frames = '0;
         // occasional discontinuity
         stamp = ($urandom_range(24) == 0) ? $urandom : gen_stamp;
         case ($urandom_range(39))
            0: gen_us = gen_us - $urandom_range(100000, 1);
            1: gen_us = gen_us + {$urandom, $urandom};
            default: gen_us = gen_us + $urandom_range(30000);
         endcase
         gen_clock = stamp + gen_delay + $urandom_range(4000);
         send_event(OP_PACKET, stamp, frames, gen_clock - 32'd2000, gen_us, held,
            gen_clock + $urandom_range(500));
         if (frames != 0)
            gen_stamp = stamp + {16'd0, frames};
      end else if (pick < 80) begin
         frames = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
         send_event(OP_PLAYED, $urandom, frames, $urandom, {$urandom, $urandom}, held,
            gen_clock + $urandom_range(500));
      end else if (pick < 90) begin
         send_event(OP_QUERY, $urandom, 16'($urandom), $urandom, {$urandom, $urandom}, held,
            gen_clock + $urandom_range(500));
      end else if (pick < 93) begin
         send_event(OP_STREAM_RESET, $urandom, 16'($urandom), $urandom, {$urandom, $urandom},
            16'($urandom), $urandom);
      end else begin
         send_event(op_type'($urandom_range(3)), $urandom, 16'($urandom), $urandom,
            {$urandom, $urandom}, 16'($urandom), $urandom);
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_event(OP_QUERY, 0, 0, 0, 0, 0, 0);
      send_event(OP_PACKET, 32'd1000, 16'd480, 32'd1500, 64'd0, 16'd0, 32'd2000);
      send_event(OP_PACKET, 32'd1480, 16'd480, 32'd1970, 64'd10, 16'd480, 32'd2600);
      // zero frames: mismatched stamp must not count as a break
      send_event(OP_PACKET, 32'd777, 16'd0, 32'd5, 64'd20, 16'd0, 32'd2600);
      send_event(OP_PACKET, 32'd1960, 16'd1, 32'd1900, 64'd1000011, 16'hFFFF, 32'hFFFF_FFFF);
      send_event(OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 64'd1000012, 16'd1000, 32'd0);
      send_event(OP_PLAYED, 0, 16'd400, 0, 0, 16'd0, 32'd100);
      send_event(OP_QUERY, 0, 0, 0, 0, 16'd10, 32'd5000);
      send_event(OP_PLAYED, 0, 16'hFFFF, 0, 0, 16'd0, 32'd100);
      // time steps backwards
      send_event(OP_PACKET, 32'h0000_FFFE, 16'd1, 32'hFFFF_FFFF, 64'd0, 16'd0, 32'd12345);
      send_event(OP_PACKET, 32'h0000_FFFF, 16'd2, 32'h0001_0000, 64'hFFFF_FFFF_FFFF_FFFF,
         16'd2, 32'h8000_0000);
      send_event(OP_PLAYED, 0, 16'd0, 0, 0, 16'd1, 32'd7);
      send_event(OP_STREAM_RESET, $urandom, 16'($urandom), $urandom, {$urandom, $urandom},
         16'($urandom), $urandom);
      send_event(OP_QUERY, 0, 0, 0, 0, 0, 0);
      send_event(OP_PACKET, 32'h1234_5678, 16'd100, 32'h1234_9000, 64'd500, 16'd0,
         32'h1235_0000);
      send_event(OP_PACKET, 32'd0, 16'd1, 32'd0, 64'd600, 16'd0, 32'd50);
      send_event(OP_PLAYED, 0, 16'd1, 0, 0, 16'd0, 32'd60);
      send_event(OP_QUERY, 0, 0, 0, 0, 16'hFFFF, 32'hFFFF_FFFF);
      send_event(OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
         16'hFFFF, 32'hFFFF_FFFF);
      send_event(OP_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
         16'hFFFF, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   task automatic test_random_streams(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      gen_stamp = $urandom;
      gen_us = {$urandom, $urandom};
      gen_delay = $urandom;
      gen_clock = gen_stamp + gen_delay;
      repeat (count) send_stream_item();
      wait_idle();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // long receiver hold-off while events keep coming
      rsp_hold_cycles = 400;
      repeat (40) send_stream_item();
      wait_idle();
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      configure(32'd0, 32'hFFFF_FFFF);
      test_random_streams(280, 0, 0);
      configure(32'd1, 32'd0);
      test_random_streams(280, 55, 0);
      configure(32'hFFFF_FFFF, 32'd480);
      test_random_streams(280, 0, 55);
      configure(32'd100000, $urandom);
      test_random_streams(280, 34, 34);
      configure(WINDOW_LENGTH_RESET, 32'($urandom_range(4000)));
      test_backpressure();
      configure($urandom_range(200000, 20000), $urandom);
      test_random_streams(280, 0, 0);
      if (mismatches == 0 && expected_reports.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
